### rtl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared widths, constants and types of the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

  // port widths
  localparam int unsigned CAL_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned RAW_W      = 24;
  localparam int unsigned TEMP_OUT_W = 15;
  localparam int unsigned PRES_OUT_W = 17;

  // internal widths, sized from the ranges of the 24-bit inputs and 16-bit words
  localparam int unsigned DT_W    = RAW_W + 1;
  localparam int unsigned PT_W    = DT_W + CAL_W + 1;
  localparam int unsigned DD_W    = 2 * DT_W;
  localparam int unsigned T2_SH   = 31;
  localparam int unsigned T2_W    = 2 * RAW_W - T2_SH;
  localparam int unsigned TEMP1_W = 20;
  localparam int unsigned TEMP_W  = TEMP1_W + 1;
  localparam int unsigned SQ_W    = 35;
  localparam int unsigned CORR_W  = 38;
  localparam int unsigned OFF_W   = 40;
  localparam int unsigned SENS_W  = 40;
  localparam int unsigned SPLIT   = 20;
  localparam int unsigned PLO_W   = RAW_W + SPLIT;
  localparam int unsigned PHI_W   = RAW_W + 1 + SENS_W - SPLIT;
  localparam int unsigned PROD_W  = 64;
  localparam int unsigned PRE_W   = 44;
  localparam int unsigned PRES_W  = 29;

  // shift amounts of the compensation formulas
  localparam int unsigned TREF_SH  = 8;
  localparam int unsigned TEMP_SH  = 23;
  localparam int unsigned OFF_SH   = 7;
  localparam int unsigned SENS_SH  = 8;
  localparam int unsigned OFFB_SH  = 16;
  localparam int unsigned SENSB_SH = 15;
  localparam int unsigned PROD_SH  = 21;
  localparam int unsigned PRES_SH  = 15;

  // temperature thresholds and output ranges
  localparam int T_REF    = 2000;
  localparam int T_LOW    = -1500;
  localparam int TEMP_MIN = -4000;
  localparam int TEMP_MAX = 8500;
  localparam int PRES_MIN = 1000;
  localparam int PRES_MAX = 120000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENS_T1  = 3'd0,
    CFG_OFF_T1   = 3'd1,
    CFG_TCS      = 3'd2,
    CFG_TCO      = 3'd3,
    CFG_T_REF    = 3'd4,
    CFG_TEMPSENS = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
  } cal_t;

  typedef struct packed {
    logic signed [TEMP1_W-1:0] temp1;
    logic signed [OFF_W-1:0]   off1;
    logic signed [SENS_W-1:0]  sens1;
    logic [T2_W-1:0]           t2;
    logic [RAW_W-1:0]          d1;
  } first_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
    logic [RAW_W-1:0]         d1;
  } second_t;

endpackage

### rtl/bsc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bsc_cfg_regs
// Calibration word registers, written through a plain write port.
// ----------------------------------------------------------------------------
module bsc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bsc_pkg::CAL_W-1:0]     cfg_data_i,
  output bsc_pkg::cal_t                 cal_o
);
  import bsc_pkg::*;

  cal_t cal_q, cal_d;

  always_comb begin
    cal_d = cal_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SENS_T1:  cal_d.c1 = cfg_data_i;
        CFG_OFF_T1:   cal_d.c2 = cfg_data_i;
        CFG_TCS:      cal_d.c3 = cfg_data_i;
        CFG_TCO:      cal_d.c4 = cfg_data_i;
        CFG_T_REF:    cal_d.c5 = cfg_data_i;
        CFG_TEMPSENS: cal_d.c6 = cfg_data_i;
        default:      cal_d = cal_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end

  assign cal_o = cal_q;

endmodule

### rtl/bsc_first_order.sv
// ----------------------------------------------------------------------------
// bsc_first_order
// Three stages: temperature difference, calibration products, first-order
// temperature, offset and sensitivity.
// ----------------------------------------------------------------------------
module bsc_first_order (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bsc_pkg::cal_t             cal_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [bsc_pkg::RAW_W-1:0] raw_pressure_i,
  input  logic [bsc_pkg::RAW_W-1:0] raw_temperature_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output bsc_pkg::first_t           out_data_o
);
  import bsc_pkg::*;

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  // stage 1
  logic signed [DT_W-1:0] dt_d, dt_q;
  logic [RAW_W-1:0]       d1_s1_q;

  // stage 2
  logic signed [PT_W-1:0] pt_d, pt_q;
  logic signed [PT_W-1:0] poff_d, poff_q;
  logic signed [PT_W-1:0] psens_d, psens_q;
  logic signed [DD_W-1:0] pdd_d, pdd_q;
  logic [RAW_W-1:0]       d1_s2_q;

  // stage 3
  first_t res_d, res_q;

  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  assign dt_d = $signed({1'b0, raw_temperature_i})
              - $signed({1'b0, cal_i.c5, {TREF_SH{1'b0}}});

  assign pt_d    = dt_q * $signed({1'b0, cal_i.c6});
  assign poff_d  = $signed({1'b0, cal_i.c4}) * dt_q;
  assign psens_d = $signed({1'b0, cal_i.c3}) * dt_q;
  assign pdd_d   = dt_q * dt_q;

  always_comb begin
    res_d.temp1 = $signed(TEMP1_W'(T_REF)) + $signed(TEMP1_W'(pt_q >>> TEMP_SH));
    res_d.off1  = $signed(OFF_W'({cal_i.c2, {OFFB_SH{1'b0}}}))
                + $signed(OFF_W'(poff_q >>> OFF_SH));
    res_d.sens1 = $signed(SENS_W'({cal_i.c1, {SENSB_SH{1'b0}}}))
                + $signed(SENS_W'(psens_q >>> SENS_SH));
    res_d.t2    = pdd_q[T2_SH+T2_W-1:T2_SH];
    res_d.d1    = d1_s2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      dt_q    <= dt_d;
      d1_s1_q <= raw_pressure_i;
    end
    if (en2) begin
      pt_q    <= pt_d;
      poff_q  <= poff_d;
      psens_q <= psens_d;
      pdd_q   <= pdd_d;
      d1_s2_q <= d1_s1_q;
    end
    if (en3) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = res_q;

endmodule

### rtl/bsc_second_order.sv
// ----------------------------------------------------------------------------
// bsc_second_order
// Three stages: squared temperature deviations, low-temperature corrections,
// corrected temperature, offset and sensitivity.
// ----------------------------------------------------------------------------
module bsc_second_order (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bsc_pkg::first_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bsc_pkg::second_t out_data_o
);
  import bsc_pkg::*;

  logic v4_q, v5_q, v6_q;
  logic en4, en5, en6;

  // stage 4
  logic signed [TEMP1_W-1:0]   dev_a, dev_b;
  logic signed [2*TEMP1_W-1:0] sqa_full, sqb_full;
  logic [SQ_W-1:0]             sqa_q, sqb_q;
  logic                        lt_ref_q, lt_low_q;
  first_t                      f_q;

  // stage 5
  logic [CORR_W-1:0]        sqa5, sqb7, sqb11;
  logic [CORR_W-1:0]        off2_d, off2_q, sens2_d, sens2_q;
  logic signed [TEMP_W-1:0] temp_d, temp_q;
  logic signed [OFF_W-1:0]  off1_q;
  logic signed [SENS_W-1:0] sens1_q;
  logic [RAW_W-1:0]         d1_s5_q;

  // stage 6
  second_t res_d, res_q;

  assign en6 = !v6_q || out_ready_i;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign in_ready_o = en4;

  assign dev_a    = in_data_i.temp1 - TEMP1_W'(T_REF);
  assign dev_b    = in_data_i.temp1 - TEMP1_W'(T_LOW);
  assign sqa_full = dev_a * dev_a;
  assign sqb_full = dev_b * dev_b;

  // 5*a^2 and 11*b^2 as shift-add, 7*b^2 as shift-subtract
  assign sqa5  = (CORR_W'(sqa_q) << 2) + CORR_W'(sqa_q);
  assign sqb7  = (CORR_W'(sqb_q) << 3) - CORR_W'(sqb_q);
  assign sqb11 = (CORR_W'(sqb_q) << 3) + (CORR_W'(sqb_q) << 1) + CORR_W'(sqb_q);

  always_comb begin
    off2_d  = '0;
    sens2_d = '0;
    temp_d  = $signed(TEMP_W'(f_q.temp1));
    if (lt_ref_q) begin
      off2_d  = (sqa5 >> 1) + (lt_low_q ? sqb7 : '0);
      sens2_d = (sqa5 >> 2) + (lt_low_q ? (sqb11 >> 1) : '0);
      temp_d  = $signed(TEMP_W'(f_q.temp1)) - $signed(TEMP_W'(f_q.t2));
    end
  end

  always_comb begin
    res_d.temp = temp_q;
    res_d.off  = off1_q - $signed(OFF_W'(off2_q));
    res_d.sens = sens1_q - $signed(SENS_W'(sens2_q));
    res_d.d1   = d1_s5_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en4) begin
        v4_q <= in_valid_i;
      end
      if (en5) begin
        v5_q <= v4_q;
      end
      if (en6) begin
        v6_q <= v5_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      sqa_q    <= sqa_full[SQ_W-1:0];
      sqb_q    <= sqb_full[SQ_W-1:0];
      lt_ref_q <= in_data_i.temp1 < T_REF;
      lt_low_q <= in_data_i.temp1 < T_LOW;
      f_q      <= in_data_i;
    end
    if (en5) begin
      off2_q  <= off2_d;
      sens2_q <= sens2_d;
      temp_q  <= temp_d;
      off1_q  <= f_q.off1;
      sens1_q <= f_q.sens1;
      d1_s5_q <= f_q.d1;
    end
    if (en6) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = v6_q;
  assign out_data_o  = res_q;

endmodule

### rtl/bsc_pressure.sv
// ----------------------------------------------------------------------------
// bsc_pressure
// Four stages: split raw pressure by sensitivity product, product merge,
// offset subtract and scale, range clamp into the output register.
// ----------------------------------------------------------------------------
module bsc_pressure (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  bsc_pkg::second_t                     in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [bsc_pkg::TEMP_OUT_W-1:0] temperature_o,
  output logic [bsc_pkg::PRES_OUT_W-1:0]        pressure_o,
  output logic                                 out_of_range_o
);
  import bsc_pkg::*;

  logic v7_q, v8_q, v9_q, v10_q;
  logic en7, en8, en9, en10;

  // stage 7
  logic [PLO_W-1:0]         plo_d, plo_q;
  logic signed [PHI_W-1:0]  phi_d, phi_q;
  logic signed [TEMP_W-1:0] temp_s7_q, temp_s8_q, temp_s9_q;
  logic signed [OFF_W-1:0]  off_s7_q, off_s8_q;

  // stage 8
  logic signed [PROD_W-1:0] prod_d, prod_q;

  // stage 9
  logic signed [PRE_W-1:0]  pre;
  logic signed [PRES_W-1:0] pres_d, pres_q;

  // output stage
  logic signed [TEMP_OUT_W-1:0] temp_o_d, temp_o_q;
  logic [PRES_OUT_W-1:0]        pres_o_d, pres_o_q;
  logic                         oor_d, oor_q;

  assign en10 = !v10_q || out_ready_i;
  assign en9  = !v9_q || en10;
  assign en8  = !v8_q || en9;
  assign en7  = !v7_q || en8;
  assign in_ready_o = en7;

  // sensitivity cut into an unsigned low part and a signed high part
  assign plo_d = PLO_W'(in_data_i.d1) * PLO_W'(in_data_i.sens[SPLIT-1:0]);
  assign phi_d = $signed({1'b0, in_data_i.d1}) * $signed(in_data_i.sens[SENS_W-1:SPLIT]);

  assign prod_d = ($signed(PROD_W'(phi_q)) <<< SPLIT) + $signed(PROD_W'(plo_q));

  assign pre    = $signed(PRE_W'(prod_q >>> PROD_SH)) - $signed(PRE_W'(off_s8_q));
  assign pres_d = $signed(PRES_W'(pre >>> PRES_SH));

  always_comb begin
    oor_d    = 1'b0;
    temp_o_d = TEMP_OUT_W'(temp_s9_q);
    pres_o_d = PRES_OUT_W'(pres_q);
    if (temp_s9_q < TEMP_MIN) begin
      temp_o_d = TEMP_OUT_W'(TEMP_MIN);
      oor_d    = 1'b1;
    end else if (temp_s9_q > TEMP_MAX) begin
      temp_o_d = TEMP_OUT_W'(TEMP_MAX);
      oor_d    = 1'b1;
    end
    if (pres_q < PRES_MIN) begin
      pres_o_d = PRES_OUT_W'(PRES_MIN);
      oor_d    = 1'b1;
    end else if (pres_q > PRES_MAX) begin
      pres_o_d = PRES_OUT_W'(PRES_MAX);
      oor_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
    end else begin
      if (en7) begin
        v7_q <= in_valid_i;
      end
      if (en8) begin
        v8_q <= v7_q;
      end
      if (en9) begin
        v9_q <= v8_q;
      end
      if (en10) begin
        v10_q <= v9_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en7) begin
      plo_q     <= plo_d;
      phi_q     <= phi_d;
      temp_s7_q <= in_data_i.temp;
      off_s7_q  <= in_data_i.off;
    end
    if (en8) begin
      prod_q    <= prod_d;
      temp_s8_q <= temp_s7_q;
      off_s8_q  <= off_s7_q;
    end
    if (en9) begin
      pres_q    <= pres_d;
      temp_s9_q <= temp_s8_q;
    end
    if (en10) begin
      temp_o_q <= temp_o_d;
      pres_o_q <= pres_o_d;
      oor_q    <= oor_d;
    end
  end

  assign out_valid_o    = v10_q;
  assign temperature_o  = temp_o_q;
  assign pressure_o     = pres_o_q;
  assign out_of_range_o = oor_q;

endmodule

### rtl/baro_sensor_compensation.sv
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// Second-order compensation of raw barometric pressure and temperature.
// ----------------------------------------------------------------------------
// A beat of raw pressure and raw temperature is accepted every cycle while
// in_ready_o is high; its compensated temperature (0.01 degC) and pressure
// (0.01 mbar) are clamped to the sensor range, out_of_range set on a clamp.
// The multiplier chain has ten register stages: three for the first-order
// terms, three for the low-temperature correction, four for the pressure
// product, scaling and clamp. A stalled output holds the pipeline; empty stages
// keep filling while the result waits. The user must write calibration words
// through cfg_we_i only while the pipeline is empty; no logic enforces it.
module baro_sensor_compensation (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [bsc_pkg::CAL_W-1:0]            cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [bsc_pkg::RAW_W-1:0]            raw_pressure_i,
  input  logic [bsc_pkg::RAW_W-1:0]            raw_temperature_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [bsc_pkg::TEMP_OUT_W-1:0] temperature_o,
  output logic [bsc_pkg::PRES_OUT_W-1:0]        pressure_o,
  output logic                                 out_of_range_o
);
  import bsc_pkg::*;

  cal_t    cal;
  first_t  first_data;
  second_t second_data;
  logic    first_valid, first_ready;
  logic    second_valid, second_ready;

  bsc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cal_o       (cal)
  );

  bsc_first_order u_first (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cal_i             (cal),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .out_valid_o       (first_valid),
    .out_ready_i       (first_ready),
    .out_data_o        (first_data)
  );

  bsc_second_order u_second (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (first_valid),
    .in_ready_o  (first_ready),
    .in_data_i   (first_data),
    .out_valid_o (second_valid),
    .out_ready_i (second_ready),
    .out_data_o  (second_data)
  );

  bsc_pressure u_pressure (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (second_valid),
    .in_ready_o     (second_ready),
    .in_data_i      (second_data),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .temperature_o  (temperature_o),
    .pressure_o     (pressure_o),
    .out_of_range_o (out_of_range_o)
  );

  // clamp keeps the delivered temperature inside the sensor range
  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (temperature_o >= TEMP_MIN && temperature_o <= TEMP_MAX))
    else $error("temperature outside clamp range");

  a_pres_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pressure_o >= PRES_MIN && pressure_o <= PRES_MAX))
    else $error("pressure outside clamp range");

  // input back-pressure only when every stage is full behind a stalled output
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && first_valid && second_valid))
    else $error("input stalled while the pipeline can move");

endmodule

### verif/baro_sensor_compensation_tb.sv
// ----------------------------------------------------------------------------
// baro_sensor_compensation_tb
// Self-checking bench for the barometric compensation pipeline.
// ----------------------------------------------------------------------------
// Drives raw pressure/temperature beats through the valid/ready input and
// computes each compensated reading with an integer model of the datasheet
// formulas, including both cold corrections and the output clamp. Readings
// are compared in order. Calibration words are rewritten between phases
// while the pipeline is empty, and each phase uses one of four idle patterns.
module baro_sensor_compensation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsc_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned PHASE_ITEMS  = 140;
  localparam int unsigned NUM_PHASES   = 8;
  // indexes past the last calibration word, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef struct packed {
    logic signed [TEMP_OUT_W-1:0] temp;
    logic [PRES_OUT_W-1:0]        pres;
    logic                         clamped;
  } reading_t;

  class compensation_checker;
    cal_t     cal;
    reading_t pending_readings[$];
    int       errors;
    int       checked;
    int       n_cold;
    int       n_deep_cold;
    int       n_clamped;

    function new();
      cal = '0;
    endfunction

    function void set_word(logic [CFG_IDX_W-1:0] idx, logic [CAL_W-1:0] val);
      case (idx)
        CFG_SENS_T1:  cal.c1 = val;
        CFG_OFF_T1:   cal.c2 = val;
        CFG_TCS:      cal.c3 = val;
        CFG_TCO:      cal.c4 = val;
        CFG_T_REF:    cal.c5 = val;
        CFG_TEMPSENS: cal.c6 = val;
        default: ;
      endcase
    endfunction

    function void note_sample(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
      longint dt, t, off, sens, t2, off2, sens2, pres, a, b;
      reading_t r;
      dt   = longint'(d2) - (longint'(cal.c5) <<< TREF_SH);
      t    = T_REF + ((dt * longint'(cal.c6)) >>> TEMP_SH);
      off  = (longint'(cal.c2) <<< OFFB_SH) + ((longint'(cal.c4) * dt) >>> OFF_SH);
      sens = (longint'(cal.c1) <<< SENSB_SH) + ((longint'(cal.c3) * dt) >>> SENS_SH);
      t2 = 0;
      off2 = 0;
      sens2 = 0;
      // both cold tests look at the first-order temperature
      if (t < T_REF) begin
        n_cold++;
        a     = t - T_REF;
        t2    = (dt * dt) >>> T2_SH;
        off2  = (5 * a * a) >>> 1;
        sens2 = (5 * a * a) >>> 2;
        if (t < T_LOW) begin
          n_deep_cold++;
          b     = t - T_LOW;
          off2  += 7 * b * b;
          sens2 += (11 * b * b) >>> 1;
        end
      end
      t    -= t2;
      off  -= off2;
      sens -= sens2;
      pres = (((longint'(d1) * sens) >>> PROD_SH) - off) >>> PRES_SH;
      r.clamped = 1'b0;
      if (t < TEMP_MIN) begin
        t = TEMP_MIN;
        r.clamped = 1'b1;
      end
      if (t > TEMP_MAX) begin
        t = TEMP_MAX;
        r.clamped = 1'b1;
      end
      if (pres < PRES_MIN) begin
        pres = PRES_MIN;
        r.clamped = 1'b1;
      end
      if (pres > PRES_MAX) begin
        pres = PRES_MAX;
        r.clamped = 1'b1;
      end
      if (r.clamped) n_clamped++;
      r.temp = t[TEMP_OUT_W-1:0];
      r.pres = pres[PRES_OUT_W-1:0];
      pending_readings.push_back(r);
    endfunction

    function void check_reading(logic signed [TEMP_OUT_W-1:0] temp,
                                logic [PRES_OUT_W-1:0] pres, logic clamped);
      reading_t e;
      if (pending_readings.size() == 0) begin
        $display("%0t unexpected reading: temperature %0d pressure %0d flag %0b",
                 $time, temp, pres, clamped);
        errors++;
        return;
      end
      e = pending_readings.pop_front();
      checked++;
      if (temp !== e.temp) begin
        $display("%0t temperature mismatch: expected %0d actual %0d", $time, e.temp, temp);
        errors++;
      end
      if (pres !== e.pres) begin
        $display("%0t pressure mismatch: expected %0d actual %0d", $time, e.pres, pres);
        errors++;
      end
      if (clamped !== e.clamped) begin
        $display("%0t out_of_range mismatch: expected %0b actual %0b",
                 $time, e.clamped, clamped);
        errors++;
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [CFG_IDX_W-1:0]         cfg_index_i;
  logic [CAL_W-1:0]             cfg_data_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [RAW_W-1:0]             raw_pressure_i;
  logic [RAW_W-1:0]             raw_temperature_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic signed [TEMP_OUT_W-1:0] temperature_o;
  logic [PRES_OUT_W-1:0]        pressure_o;
  logic                         out_of_range_o;

  compensation_checker sb = new();
  int unsigned cycles;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          cal_sets;

  baro_sensor_compensation u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .temperature_o     (temperature_o),
    .pressure_o        (pressure_o),
    .out_of_range_o    (out_of_range_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d readings still pending",
               cycles, sb.pending_readings.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // accepted beats on both sides, sampled before this edge's updates land
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_sample(raw_pressure_i, raw_temperature_i);
      if (out_valid_o && out_ready_i) sb.check_reading(temperature_o, pressure_o, out_of_range_o);
    end
  end

  task automatic write_word(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    sb.set_word(idx, val);
  endtask

  task automatic program_cal(input cal_t c);
    write_word(CFG_SENS_T1, c.c1);
    write_word(CFG_OFF_T1, c.c2);
    write_word(CFG_TCS, c.c3);
    write_word(CFG_TCO, c.c4);
    write_word(CFG_T_REF, c.c5);
    write_word(CFG_TEMPSENS, c.c6);
    cfg_we_i <= 1'b0;
    cal_sets++;
  endtask

  task automatic send_sample(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i        <= 1'b1;
    raw_pressure_i    <= d1;
    raw_temperature_i <= d2;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // let the pipeline empty before touching calibration
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_readings.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    cal_t   c;
    longint centre;
    logic [RAW_W-1:0] d1, d2;
    logic [RAW_W-1:0] t_probe[8];
    logic [RAW_W-1:0] p_probe[3];

    cycles            <= 0;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_index_i       <= CFG_SENS_T1;
    cfg_data_i        <= '0;
    in_valid_i        <= 1'b0;
    raw_pressure_i    <= '0;
    raw_temperature_i <= '0;
    out_ready_i       <= 1'b1;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    cal_sets          = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unprogrammed calibration straight out of reset
    send_sample('0, '0);
    send_sample('1, '1);
    send_sample(24'd9085466, 24'd8569150);
    drain();

    // c5 = c6 = 2^15 gives temp1 = 2000 + (d2 - 2^23) >> 8, so the thresholds are exact
    c = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317, c4: 16'd23282,
          c5: 16'd32768, c6: 16'd32768};
    program_cal(c);
    write_word(CFG_SPARE_A, 16'hDEAD);
    write_word(CFG_SPARE_B, 16'hBEEF);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    t_probe = '{24'h800000, 24'h7FFFFF, 24'h800000 - 24'd896000,
                24'h800000 - 24'd896000 + 24'd255, 24'h800000 - 24'd896256,
                24'h800000 - 24'd1500000, 24'h000000, 24'hFFFFFF};
    p_probe = '{24'd9085466, 24'h000000, 24'hFFFFFF};
    foreach (t_probe[i]) send_sample(p_probe[0], t_probe[i]);
    foreach (p_probe[i]) begin
      send_sample(p_probe[i], 24'h000000);
      send_sample(p_probe[i], 24'hFFFFFF);
      send_sample(p_probe[i], 24'h7FFFFF);
    end
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: c = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317, c4: 16'd23282,
                 c5: 16'd33464, c6: 16'd28312};
        1: c = '1;
        2: c = '0;
        default: begin
          c = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317, c4: 16'd23282,
                c5: 16'd33464, c6: 16'd28312};
          // mix each word among its extremes, random values and the typical one
          for (int w = 0; w < 6; w++) begin
            case ($urandom_range(3))
              0: c[w*CAL_W +: CAL_W] = '0;
              1: c[w*CAL_W +: CAL_W] = '1;
              2: c[w*CAL_W +: CAL_W] = CAL_W'($urandom());
              default: ;
            endcase
          end
        end
      endcase
      program_cal(c);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(3) != 0) begin
          // plausible sample: temperature near the reference, pressure mid-scale
          d1 = RAW_W'($urandom_range(13000000, 5000000));
          centre = longint'(sb.cal.c5) <<< TREF_SH;
          if ($urandom_range(1)) centre += longint'($urandom_range(2097151));
          else centre -= longint'($urandom_range(2097151));
          if (centre < 0) centre = 0;
          if (centre > longint'(24'hFFFFFF)) centre = longint'(24'hFFFFFF);
          d2 = centre[RAW_W-1:0];
        end else begin
          d1 = RAW_W'($urandom());
          d2 = RAW_W'($urandom());
        end
        send_sample(d1, d2);
      end
      drain();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end

    $display("%0d readings checked across %0d calibration sets and four idle patterns",
             sb.checked, cal_sets);
    $display("%0d took the cold correction, %0d the deep-cold term, %0d were clamped",
             sb.n_cold, sb.n_deep_cold, sb.n_clamped);
    if (sb.errors == 0 && sb.pending_readings.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
